### rtl/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types, codes, reset values and helpers of the retransmission
// timeout estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

	// Field widths.
	localparam int unsigned MS_W      = 31;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned GAIN_W    = 5;
	localparam int unsigned DIVR_W    = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_DATA_W = 120;
	localparam int unsigned OUT_DATA_W = 104;
	localparam int unsigned WIDE_W    = 37;
	localparam int unsigned KV_W      = 36;

	// Default retry count after which the estimate is dropped.
	localparam int unsigned RETRY_RESET_LIMIT_DEF = 5;

	// Register reset values.
	localparam logic [MS_W-1:0]   LOWER_RST = 31'd1000;
	localparam logic [MS_W-1:0]   UPPER_RST = 31'd60000;
	localparam logic [LEN_W-1:0]  GRAN_RST  = 16'd10;
	localparam logic [GAIN_W-1:0] GAIN_RST  = 5'd4;
	localparam logic [DIVR_W-1:0] SDIV_RST  = 7'd8;
	localparam logic [DIVR_W-1:0] VDIV_RST  = 7'd4;

	// Event codes.
	typedef enum logic [1:0] {
		FN_SEND = 2'd0,
		FN_RTX  = 2'd1,
		FN_ACK  = 2'd2,
		FN_NONE = 2'd3
	} func_t;

	// Result status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BUSY   = 2'd1;
	localparam logic [1:0] ST_NOPEND = 2'd2;
	localparam logic [1:0] ST_NOTQ   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SDIV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VDIV  = 3'd5;

	// Divide operand selects.
	localparam logic [1:0] DSEL_VAR  = 2'd0;
	localparam logic [1:0] DSEL_DIFF = 2'd1;
	localparam logic [1:0] DSEL_SRTT = 2'd2;
	localparam logic [1:0] DSEL_RTT  = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_in;
		logic       exec;
		logic       div_start;
		logic       div_store;
		logic       update;
		logic       out_load;
		logic [1:0] div_sel;
	} rte_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sample_go;
		logic div_done;
	} rte_sts_t;

	// Clamp a wide timeout into [lower, upper]; the lower bound wins first.
	function automatic logic [MS_W-1:0] clamp_to(input logic [WIDE_W-1:0] v,
			input logic [MS_W-1:0] lower, input logic [MS_W-1:0] upper);
		logic [MS_W-1:0] r;
		if (v < {6'd0, lower}) begin
			r = lower;
		end else if (v > {6'd0, upper}) begin
			r = upper;
		end else begin
			r = v[MS_W-1:0];
		end
		return r;
	endfunction

	// Saturate a sum to 31 bits.
	function automatic logic [MS_W-1:0] sat31(input logic [38:0] v);
		logic [MS_W-1:0] r;
		if (v[38:MS_W] != '0) begin
			r = '1;
		end else begin
			r = v[MS_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/rte_div.sv
// ----------------------------------------------------------------------------
// rte_div
// Restoring divider, 31-bit dividend by 7-bit divisor, one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [rte_pkg::MS_W-1:0]   dividend,
	input  wire logic [rte_pkg::DIVR_W-1:0] divisor,
	output logic                          done,
	output logic [rte_pkg::MS_W-1:0]        quotient
);
	import rte_pkg::*;

	logic [MS_W-1:0]   dvd_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvs_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   rem_sh;
	logic              qbit;
	logic [DIVR_W:0]   rem_sub;

	// One trial subtraction per cycle.
	always_comb begin
		rem_sh  = {rem_q, dvd_q[MS_W-1]};
		qbit    = (rem_sh >= {1'b0, dvs_q});
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MS_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[MS_W-2:0], qbit};
			rem_q <= qbit ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

### rtl/rte_dp.sv
// ----------------------------------------------------------------------------
// rte_dp
// Datapath: configuration, connection state, timeout arithmetic, the
// smoothing update and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_dp #(
	parameter int unsigned RETRY_RESET_LIMIT = rte_pkg::RETRY_RESET_LIMIT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rte_pkg::rte_cmd_t             cmd,
	output rte_pkg::rte_sts_t                  sts,
	input  wire logic                          cfg_we,
	input  wire logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rte_pkg::MS_W-1:0]       cfg_wdata,
	input  wire logic [rte_pkg::IN_DATA_W-1:0]  in_tdata,
	input  wire logic [1:0]                    in_tuser,
	output logic [rte_pkg::OUT_DATA_W-1:0]      out_tdata
);
	import rte_pkg::*;

	// Configuration.
	logic [MS_W-1:0]   lower_q, upper_q;
	logic [LEN_W-1:0]  gran_q;
	logic [GAIN_W-1:0] gain_q;
	logic [DIVR_W-1:0] sdiv_q, vdiv_q;

	// Latched input item.
	logic [1:0]       func_q;
	logic             syn_q, fin_q, rst_q, ack_q;
	logic [LEN_W-1:0] plen_q;
	logic [SEQ_W-1:0] seq_q, ackn_q, now_q;

	// Connection state.
	logic             busy_q;
	logic [SEQ_W-1:0] last_q;
	logic [7:0]       retry_q;
	logic [SEQ_W-1:0] stime_q;
	logic [MS_W-1:0]  srtt_q, var_q, cur_q;
	logic             est_q;

	// Per-item result bits and sample working registers.
	logic [1:0]      status_q;
	logic            tstart_q, tstop_q;
	logic [MS_W-1:0] rtt_q, diff_q;
	logic [MS_W-1:0] quo_q [4];
	logic [KV_W-1:0] kv_q;
	logic [OUT_DATA_W-1:0] out_q;

	logic [DIVR_W-1:0] a_eff, b_eff;
	logic [SEQ_W-1:0]  dlt;
	logic              hit, rtt_ok, rst_like;
	logic [WIDE_W-1:0] t_send, t_rtx;
	logic [KV_W-1:0]   vterm;
	logic [MS_W-1:0]   div_dvd;
	logic [DIVR_W-1:0] div_dvs;
	logic              div_done;
	logic [MS_W-1:0]   div_quo;
	logic [38:0]       var_sum, srtt_sum;

	assign a_eff = (sdiv_q == '0) ? 7'd1 : sdiv_q;
	assign b_eff = (vdiv_q == '0) ? 7'd1 : vdiv_q;

	// Event decode.
	always_comb begin
		dlt      = now_q - stime_q;
		hit      = ((last_q - ackn_q) & 32'h8000_0000) != '0;
		rtt_ok   = (retry_q == '0) && (dlt != '0) && !dlt[SEQ_W-1];
		rst_like = rst_q || (ack_q && !syn_q && !fin_q && (plen_q == '0));
		vterm    = (kv_q > {20'd0, gran_q}) ? kv_q : {20'd0, gran_q};
		t_send   = est_q ? ({6'd0, srtt_q} + {1'b0, vterm}) : {6'd0, lower_q};
		t_rtx    = {5'd0, cur_q, 1'b0};
		sts.sample_go = (func_q == FN_ACK) && busy_q && hit && rtt_ok && est_q;
		sts.div_done  = div_done;
	end

	// Divider operand selection.
	always_comb begin
		case (cmd.div_sel)
			DSEL_VAR:  div_dvd = var_q;
			DSEL_DIFF: div_dvd = diff_q;
			DSEL_SRTT: div_dvd = srtt_q;
			default:   div_dvd = rtt_q;
		endcase
		div_dvs = cmd.div_sel[1] ? a_eff : b_eff;
	end

	rte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Smoothing sums from stored quotients.
	always_comb begin
		var_sum  = 39'(quo_q[DSEL_VAR]) * 39'(b_eff - 7'd1) + 39'(quo_q[DSEL_DIFF]);
		srtt_sum = 39'(quo_q[DSEL_SRTT]) * 39'(a_eff - 7'd1) + 39'(quo_q[DSEL_RTT]);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RST;
			upper_q <= UPPER_RST;
			gran_q  <= GRAN_RST;
			gain_q  <= GAIN_RST;
			sdiv_q  <= SDIV_RST;
			vdiv_q  <= VDIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOWER: lower_q <= cfg_wdata;
				CFG_UPPER: upper_q <= cfg_wdata;
				CFG_GRAN:  gran_q  <= cfg_wdata[LEN_W-1:0];
				CFG_GAIN:  gain_q  <= cfg_wdata[GAIN_W-1:0];
				CFG_SDIV:  sdiv_q  <= cfg_wdata[DIVR_W-1:0];
				CFG_VDIV:  vdiv_q  <= cfg_wdata[DIVR_W-1:0];
				default: ;
			endcase
		end
	end

	// Input capture, scaled variance, divider results and the output register.
	always_ff @(posedge clk) begin
		kv_q <= KV_W'(gain_q) * KV_W'(var_q);
		if (cmd.load_in) begin
			func_q <= in_tuser;
			syn_q  <= in_tdata[0];
			fin_q  <= in_tdata[1];
			rst_q  <= in_tdata[2];
			ack_q  <= in_tdata[3];
			plen_q <= in_tdata[19:4];
			seq_q  <= in_tdata[51:20];
			ackn_q <= in_tdata[83:52];
			now_q  <= in_tdata[115:84];
		end
		if (cmd.div_store) begin
			quo_q[cmd.div_sel] <= div_quo;
		end
		if (cmd.out_load) begin
			out_q <= {6'd0, est_q, var_q, srtt_q, cur_q, tstop_q, tstart_q, status_q};
		end
	end

	// Connection state and event handling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			last_q   <= '0;
			retry_q  <= '0;
			stime_q  <= '0;
			srtt_q   <= '0;
			var_q    <= '0;
			est_q    <= 1'b0;
			cur_q    <= '0;
			status_q <= ST_OK;
			tstart_q <= 1'b0;
			tstop_q  <= 1'b0;
			rtt_q    <= '0;
			diff_q   <= '0;
		end else if (cmd.exec) begin
			status_q <= ST_OK;
			tstart_q <= 1'b0;
			tstop_q  <= 1'b0;
			case (func_q)
				FN_SEND: begin
					retry_q <= '0;
					stime_q <= now_q;
					if (busy_q) begin
						status_q <= ST_BUSY;
					end else if (rst_like) begin
						status_q <= ST_NOTQ;
					end else begin
						busy_q   <= 1'b1;
						last_q   <= seq_q + {16'd0, plen_q} + {31'd0, syn_q}
							+ {31'd0, fin_q} - 32'd1;
						cur_q    <= clamp_to(t_send, lower_q, upper_q);
						tstart_q <= 1'b1;
					end
				end
				FN_RTX: begin
					if (!busy_q) begin
						status_q <= ST_NOPEND;
					end else begin
						if (retry_q >= 8'(RETRY_RESET_LIMIT)) begin
							srtt_q <= '0;
							var_q  <= '0;
							est_q  <= 1'b0;
						end
						cur_q    <= clamp_to(t_rtx, lower_q, upper_q);
						tstart_q <= 1'b1;
						if (retry_q != 8'hFF) begin
							retry_q <= retry_q + 8'd1;
						end
					end
				end
				FN_ACK: begin
					if (!busy_q) begin
						status_q <= ST_NOPEND;
					end else if (hit) begin
						busy_q  <= 1'b0;
						tstop_q <= 1'b1;
						if (rtt_ok) begin
							rtt_q  <= dlt[MS_W-1:0];
							diff_q <= (srtt_q > dlt[MS_W-1:0]) ? srtt_q - dlt[MS_W-1:0]
								: dlt[MS_W-1:0] - srtt_q;
							// First sample seeds the estimate directly.
							if (!est_q) begin
								srtt_q <= dlt[MS_W-1:0];
								var_q  <= {1'b0, dlt[MS_W-1:1]};
								est_q  <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.update) begin
			var_q  <= sat31(var_sum);
			srtt_q <= sat31(srtt_sum);
		end
	end

	assign out_tdata = out_q;

endmodule

`default_nettype wire

### rtl/rte_ctrl.sv
// ----------------------------------------------------------------------------
// rte_ctrl
// Controller: stream handshakes and sequencing of event handling, the four
// divisions of a smoothing update and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output rte_pkg::rte_cmd_t      cmd,
	input  wire rte_pkg::rte_sts_t sts
);
	import rte_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_DGO   = 6'b000100,
		S_DWAIT = 6'b001000,
		S_UPD   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] sel_q, sel_d;
	logic       mvalid_q;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				sel_d    = DSEL_VAR;
				state_d  = sts.sample_go ? S_DGO : S_OUT;
			end
			S_DGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					if (sel_q == DSEL_RTT) begin
						state_d = S_UPD;
					end else begin
						sel_d   = sel_q + 2'd1;
						state_d = S_DGO;
					end
				end
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!mvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= DSEL_VAR;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			// Output register holds its item until taken.
			if (cmd.out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;

endmodule

`default_nettype wire

### rtl/retransmit_timeout_estimator.sv
// ----------------------------------------------------------------------------
// retransmit_timeout_estimator
// TCP retransmission timeout tracker for one connection with one slot.
// ----------------------------------------------------------------------------
// Events are taken one at a time. A send, a retransmit or an acknowledgment
// that takes no new RTT sample passes from acceptance through the execute
// and output states; an acknowledgment that updates an existing estimate
// also makes four passes through the shared bit-serial divider, each with
// its start and wait states, and an update state before the output state,
// which waits while an earlier result is still untaken. The next event
// is accepted as soon as the previous result is in the output register,
// even while that result still waits to be taken.
`default_nettype none

module retransmit_timeout_estimator #(
	parameter int unsigned RETRY_RESET_LIMIT = rte_pkg::RETRY_RESET_LIMIT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// syn[0] fin[1] rst[2] ack[3] data_len[19:4] seg_seq[51:20]
	// ack_num[83:52] now_ms[115:84]
	input  wire logic [rte_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  wire logic [1:0]                    s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// status[1:0] timer_start[2] timer_stop[3] timeout_ms[34:4]
	// smoothed_rtt_out[65:35] rtt_variance_out[96:66] estimate_valid_out[97]
	output logic [rte_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [rte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rte_pkg::MS_W-1:0]       cfg_wdata
);
	import rte_pkg::*;

	rte_cmd_t cmd;
	rte_sts_t sts;

	rte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	rte_dp #(
		.RETRY_RESET_LIMIT (RETRY_RESET_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_tdata  (s_tdata),
		.in_tuser  (s_tuser),
		.out_tdata (m_tdata)
	);

endmodule

`default_nettype wire

### rtl/rte_checker.sv
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks of the retransmission timeout estimator.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [rte_pkg::OUT_DATA_W-1:0] m_tdata
);
	import rte_pkg::*;

	// Items are handled one at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in work");

	// A waiting result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// Timer is never armed and cancelled by the same item.
	a_timer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
		else $error("timer start and stop together");

	// Arming the timer only happens on a successful event.
	a_start_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[1:0] == ST_OK))
		else $error("timer armed with a failing status");

	// Without an estimate the smoothed values are zero.
	a_est_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[97]) |-> (m_tdata[96:35] == '0))
		else $error("estimate values nonzero while invalid");

endmodule

bind retransmit_timeout_estimator rte_checker u_rte_checker (.*);

`default_nettype wire

### tb/sv/retransmit_timeout_estimator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// retransmit_timeout_estimator_test
// Self-checking bench for the retransmission timeout estimator. Send,
// retransmit and acknowledgment items are streamed through the block under
// several register settings; a timeout predictor scores every result.
// ----------------------------------------------------------------------------

import rte_pkg::*;

// Fields of one input item, apart from the event code.
typedef struct {
	bit        syn;
	bit        fin;
	bit        rst;
	bit        ack;
	bit [15:0] plen;
	bit [31:0] seq;
	bit [31:0] ackn;
	bit [31:0] now;
} seg_item_t;

// Fields of one result item, highest bit first, as laid out in m_tdata.
typedef struct packed {
	logic                   est_valid;
	logic [MS_W-1:0]        rttvar;
	logic [MS_W-1:0]        srtt;
	logic [MS_W-1:0]        rto;
	logic                   tstop;
	logic                   tstart;
	logic [1:0]             status;
} rto_result_t;

// Timeout predictor with its own state and the queue of expected results.
class rto_scoreboard;
	longint unsigned lower, upper, gran, gain, sdiv, vdiv;
	bit        busy;
	bit [31:0] seg_end;
	int unsigned retries;
	bit [31:0] sent_at;
	longint unsigned srtt, rttvar, cur_rto;
	bit        est_ok;
	rto_result_t rto_q[$];
	int unsigned mismatches;
	int unsigned results_seen;

	function new();
		lower = LOWER_RST;
		upper = UPPER_RST;
		gran = GRAN_RST;
		gain = GAIN_RST;
		sdiv = SDIV_RST;
		vdiv = VDIV_RST;
		busy = 0;
		seg_end = 0;
		retries = 0;
		sent_at = 0;
		srtt = 0;
		rttvar = 0;
		cur_rto = 0;
		est_ok = 0;
		mismatches = 0;
		results_seen = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [MS_W-1:0] val);
		case (idx)
			CFG_LOWER: lower = val;
			CFG_UPPER: upper = val;
			CFG_GRAN: gran = val[15:0];
			CFG_GAIN: gain = val[4:0];
			CFG_SDIV: sdiv = val[6:0];
			CFG_VDIV: vdiv = val[6:0];
			default: ;
		endcase
	endfunction

	// The lower bound is tested first, so it wins when the bounds cross.
	function longint unsigned clamp_rto(longint unsigned v);
		if (v < lower) return lower;
		if (v > upper) return upper;
		return v;
	endfunction

	function longint unsigned sat_ms(longint unsigned v);
		return (v > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : v;
	endfunction

	// Smoothing of the RTT and its variance from one clean sample.
	function void take_rtt(longint unsigned rtt);
		longint unsigned a, b, diff;
		a = (sdiv == 0) ? 1 : sdiv;
		b = (vdiv == 0) ? 1 : vdiv;
		if (!est_ok) begin
			srtt = rtt;
			rttvar = rtt >> 1;
			est_ok = 1;
			return;
		end
		diff = (srtt > rtt) ? srtt - rtt : rtt - srtt;
		rttvar = sat_ms((rttvar / b) * (b - 1) + diff / b);
		srtt = sat_ms((srtt / a) * (a - 1) + rtt / a);
	endfunction

	function void note_item(func_t f, seg_item_t e);
		rto_result_t r;
		longint unsigned t, kv;
		bit [31:0] seglen, d;
		r = '0;
		case (f)
			FN_SEND: begin
				retries = 0;
				sent_at = e.now;
				if (busy) begin
					r.status = ST_BUSY;
				end else if (e.rst || (e.ack && !e.syn && !e.fin && e.plen == 0)) begin
					r.status = ST_NOTQ;
				end else begin
					seglen = e.plen + e.syn + e.fin;
					busy = 1;
					seg_end = e.seq + seglen - 1;
					if (!est_ok) begin
						t = lower;
					end else begin
						kv = gain * rttvar;
						t = srtt + ((kv > gran) ? kv : gran);
					end
					cur_rto = clamp_rto(t);
					r.tstart = 1;
				end
			end
			FN_RTX: begin
				if (!busy) begin
					r.status = ST_NOPEND;
				end else begin
					t = cur_rto * 2;
					// Too many retries: the estimate is no longer trusted.
					if (retries >= 5) begin
						srtt = 0;
						rttvar = 0;
						est_ok = 0;
					end
					cur_rto = clamp_rto(t);
					r.tstart = 1;
					if (retries < 255) retries++;
				end
			end
			FN_ACK: begin
				if (!busy) begin
					r.status = ST_NOPEND;
				end else if (((seg_end - e.ackn) & 32'h8000_0000) != 0) begin
					d = e.now - sent_at;
					busy = 0;
					r.tstop = 1;
					// Karn's rule: only never-retransmitted segments are timed.
					if (retries == 0 && d != 0 && !d[31]) take_rtt(d);
				end
			end
			default: ;
		endcase
		r.rto = cur_rto[MS_W-1:0];
		r.srtt = srtt[MS_W-1:0];
		r.rttvar = rttvar[MS_W-1:0];
		r.est_valid = est_ok;
		rto_q.push_back(r);
	endfunction

	function void check_result(logic [OUT_DATA_W-1:0] d);
		rto_result_t got, want;
		got = d[$bits(rto_result_t)-1:0];
		results_seen++;
		if (rto_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result item %h", got);
			return;
		end
		want = rto_q.pop_front();
		if (got.status !== want.status || got.tstart !== want.tstart ||
				got.tstop !== want.tstop || got.rto !== want.rto ||
				got.srtt !== want.srtt || got.rttvar !== want.rttvar ||
				got.est_valid !== want.est_valid) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d: expected st=%0d start=%0d stop=%0d rto=%0d srtt=%0d var=%0d est=%0d",
					results_seen, want.status, want.tstart, want.tstop, want.rto,
					want.srtt, want.rttvar, want.est_valid);
				$display("result %0d: actual   st=%0d start=%0d stop=%0d rto=%0d srtt=%0d var=%0d est=%0d",
					results_seen, got.status, got.tstart, got.tstop, got.rto,
					got.srtt, got.rttvar, got.est_valid);
			end
		end
	endfunction
endclass

module retransmit_timeout_estimator_test;

	localparam int unsigned CYCLE_LIMIT = 1500000;
	localparam int unsigned ITEMS_PER_PHASE = 270;

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata;
	logic [1:0]              s_tuser;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [MS_W-1:0]         cfg_wdata;

	rto_scoreboard sb;
	int unsigned cycles;
	int unsigned items_sent;
	int unsigned burst_left;
	int unsigned stall_pct;
	int unsigned holdoff_req;
	int unsigned holdoff_seen;
	int unsigned holdoff_cnt;
	bit [31:0]   clock_ms;

	retransmit_timeout_estimator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Free-running clock.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Run-length guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.rto_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (holdoff_req != holdoff_seen) begin
			holdoff_seen <= holdoff_req;
			holdoff_cnt <= 600;
			m_tready <= 1'b0;
		end else if (holdoff_cnt != 0) begin
			holdoff_cnt <= holdoff_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Result checking at the accepting edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	function automatic logic [IN_DATA_W-1:0] pack_item(seg_item_t e);
		return {4'd0, e.now, e.ackn, e.seq, e.plen, e.ack, e.rst, e.fin, e.syn};
	endfunction

	// Offer one item in a burst pattern; called and returning at a falling edge.
	task automatic push_item(func_t f, seg_item_t e);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_item(e);
		s_tuser <= f;
		do @(posedge clk); while (!s_tready);
		sb.note_item(f, e);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Wait until every expected result has come back and the block is idle.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.rto_q.size() != 0) @(negedge clk);
		repeat (160) @(negedge clk);
	endtask

	task automatic set_regs(logic [MS_W-1:0] lo, logic [MS_W-1:0] hi,
			logic [MS_W-1:0] gr, logic [MS_W-1:0] gn, logic [MS_W-1:0] sd,
			logic [MS_W-1:0] vd);
		logic [MS_W-1:0] vals [6];
		vals = '{lo, hi, gr, gn, sd, vd};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_wdata <= vals[i];
			sb.write_reg(i[CFG_IDX_W-1:0], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic seg_item_t make_seg(bit syn, bit fin, bit rst, bit ack,
			bit [15:0] plen, bit [31:0] seq, bit [31:0] ackn, bit [31:0] now);
		seg_item_t e;
		e.syn = syn;
		e.fin = fin;
		e.rst = rst;
		e.ack = ack;
		e.plen = plen;
		e.seq = seq;
		e.ackn = ackn;
		e.now = now;
		return e;
	endfunction

	function automatic seg_item_t rand_seg();
		return make_seg(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
			16'($urandom), $urandom, $urandom, $urandom);
	endfunction

	// One send/retransmit/acknowledge exchange with random content.
	task automatic run_exchange();
		seg_item_t e;
		bit [31:0] last;
		bit [31:0] rtt;
		int unsigned nrtx, pick;
		e = make_seg($urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0,
			$urandom_range(0, 30) == 0, 1'($urandom), 16'($urandom), $urandom,
			$urandom, 0);
		e.plen = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
			: 16'($urandom_range(0, 1500));
		clock_ms += $urandom_range(0, 5000);
		e.now = clock_ms;
		last = e.seq + e.plen + e.syn + e.fin - 1;
		push_item(FN_SEND, e);
		// A second send while the slot is held.
		if ($urandom_range(0, 9) == 0) begin
			clock_ms += $urandom_range(0, 50);
			e.now = clock_ms;
			push_item(FN_SEND, e);
		end
		pick = $urandom_range(0, 99);
		if (pick < 60) nrtx = 0;
		else if (pick < 97) nrtx = $urandom_range(1, 8);
		else if (pick < 99) nrtx = $urandom_range(9, 20);
		else nrtx = $urandom_range(255, 258);
		for (int i = 0; i < nrtx; i++) begin
			e = rand_seg();
			push_item(FN_RTX, e);
		end
		// An acknowledgment that falls short of the segment end.
		if ($urandom_range(0, 4) == 0) begin
			e = rand_seg();
			e.ackn = last - $urandom_range(0, 2000);
			push_item(FN_ACK, e);
		end
		pick = $urandom_range(0, 99);
		if (pick < 80) rtt = $urandom_range(1, 3000);
		else if (pick < 85) rtt = 0;
		else if (pick < 92) rtt = $urandom;
		else rtt = $urandom_range(100000, 32'h7FFF_FFFF);
		clock_ms += rtt;
		e = rand_seg();
		e.now = clock_ms;
		e.ackn = ($urandom_range(0, 9) == 0) ? last + 1 + ($urandom & 32'h7FFF_FFFF)
			: last + $urandom_range(1, 3000);
		push_item(FN_ACK, e);
	endtask

	task automatic run_random(int unsigned count);
		int unsigned target;
		seg_item_t e;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 9) == 0) begin
				e = rand_seg();
				push_item(func_t'($urandom_range(0, 3)), e);
			end else begin
				run_exchange();
			end
		end
	endtask

	// Directed items: every event, status and timing corner once.
	task automatic run_directed();
		push_item(FN_NONE, make_seg(1, 1, 1, 1, 16'hFFFF, '1, '1, '1));
		push_item(FN_RTX, make_seg(0, 0, 0, 0, 0, 0, 0, 0));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 32'h100, 5));
		push_item(FN_SEND, make_seg(0, 0, 1, 0, 100, 1000, 0, 10));
		push_item(FN_SEND, make_seg(0, 0, 0, 1, 0, 1000, 0, 20));
		// Zero-length SYN+FIN at the top of the sequence space wraps.
		push_item(FN_SEND, make_seg(1, 1, 0, 1, 0, 32'hFFFF_FFFF, 0, 100));
		push_item(FN_SEND, make_seg(0, 0, 0, 0, 10, 5, 0, 110));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 32'h0000_0000, 150));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 32'h0000_0001, 400));
		push_item(FN_SEND, make_seg(0, 0, 0, 1, 16'hFFFF, 32'h8000_0000, 0, 1000));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 32'h8001_0000, 1350));
		// Equal timestamps: no sample.
		push_item(FN_SEND, make_seg(0, 0, 0, 0, 1, 0, 0, 2000));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 1, 2000));
		// Clock going backwards: no sample.
		push_item(FN_SEND, make_seg(0, 0, 0, 0, 1, 0, 0, 3000));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 1, 2900));
		// Retransmits past the retry limit drop the estimate.
		push_item(FN_SEND, make_seg(0, 1, 0, 0, 0, 50, 0, 4000));
		for (int i = 0; i < 7; i++) push_item(FN_RTX, make_seg(0, 0, 0, 0, 0, 0, 0, 0));
		push_item(FN_ACK, make_seg(0, 0, 0, 0, 0, 0, 51, 4500));
	endtask

	initial begin
		sb = new();
		cycles = 0;
		items_sent = 0;
		burst_left = 0;
		stall_pct = 0;
		holdoff_req = 0;
		holdoff_seen = 0;
		holdoff_cnt = 0;
		clock_ms = $urandom;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FN_SEND;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LOWER;
		cfg_wdata = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values written explicitly, then the directed items and a random run.
		set_regs(1000, 60000, 10, 4, 8, 4);
		stall_pct = 25;
		run_directed();
		run_random(ITEMS_PER_PHASE);
		drain();

		// Widest bounds, no granularity floor, no smoothing.
		set_regs(0, 31'h7FFF_FFFF, 0, 16, 1, 1);
		stall_pct = 0;
		run_random(ITEMS_PER_PHASE / 2);
		// Long receiver hold-off while items keep coming.
		holdoff_req++;
		stall_pct = 50;
		run_random(ITEMS_PER_PHASE / 2);
		drain();

		// Crossed bounds, zero divisors, largest gain field.
		set_regs(5000, 100, 65535, 31, 0, 0);
		stall_pct = 10;
		clock_ms = 32'hFFFF_F000;
		run_random(ITEMS_PER_PHASE);
		drain();

		// Tight bounds, divisors of 64, unit gain.
		set_regs(1, 200, 65535, 1, 64, 64);
		stall_pct = 70;
		run_random(ITEMS_PER_PHASE);
		drain();

		// Full register fields and zero gain.
		set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 0, 127, 127);
		stall_pct = 30;
		run_random(ITEMS_PER_PHASE);
		drain();

		// Ordinary setting with a moderate floor.
		set_regs(200, 120000, 50, 2, 16, 8);
		stall_pct = 20;
		run_random(ITEMS_PER_PHASE);
		drain();

		sb.mismatches += sb.rto_q.size();
		$display("covered %0d items and %0d results over six register settings",
			items_sent, sb.results_seen);
		$display("mismatches: %0d, cycles: %0d", sb.mismatches, cycles);
		if (sb.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
